FILE: hw/rtl/hq_pkg.sv
`timescale 1ns / 1ps

package hq_pkg;

  // Default sizing
  localparam int HQ_CAPACITY  = 64;
  localparam int HQ_KEY_WIDTH = 48;
  localparam int HQ_ID_WIDTH  = 8;

  // Fixed field widths
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

FILE: hw/rtl/hq_req_if.sv
`timescale 1ns / 1ps

interface hq_req_if
  import hq_pkg::*;
#(
  parameter int KEY_WIDTH = HQ_KEY_WIDTH,
  parameter int ID_WIDTH  = HQ_ID_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [ID_WIDTH-1:0]  entry_id;
  logic [KEY_WIDTH-1:0] entry_key;

  modport source (output valid, output kind, output entry_id, output entry_key, input ready);
  modport sink   (input valid, input kind, input entry_id, input entry_key, output ready);
endinterface

FILE: hw/rtl/hq_rsp_if.sv
`timescale 1ns / 1ps

interface hq_rsp_if
  import hq_pkg::*;
#(
  parameter int ID_WIDTH  = HQ_ID_WIDTH,
  parameter int OCC_WIDTH = $clog2(HQ_CAPACITY + 1)
);
  logic                 valid;
  logic                 ready;
  logic [ID_WIDTH-1:0]  top_id;
  logic [STATUS_W-1:0]  status;
  logic [OCC_WIDTH-1:0] occupancy;

  modport source (output valid, output top_id, output status, output occupancy, input ready);
  modport sink   (input valid, input top_id, input status, input occupancy, output ready);
endinterface

FILE: hw/rtl/hq_cmp.sv
`timescale 1ns / 1ps

// Entry priority compare: smaller key wins, equal keys go to the smaller id.
module hq_cmp #(
  parameter int KEY_WIDTH = 48,
  parameter int ID_WIDTH  = 8
) (
  input  logic [KEY_WIDTH+ID_WIDTH-1:0] a,
  input  logic [KEY_WIDTH+ID_WIDTH-1:0] b,
  output logic                          a_wins
);
  logic [KEY_WIDTH-1:0] a_key, b_key;
  logic [ID_WIDTH-1:0]  a_id, b_id;

  assign a_key = a[KEY_WIDTH+ID_WIDTH-1:ID_WIDTH];
  assign b_key = b[KEY_WIDTH+ID_WIDTH-1:ID_WIDTH];
  assign a_id  = a[ID_WIDTH-1:0];
  assign b_id  = b[ID_WIDTH-1:0];

  assign a_wins = (a_key != b_key) ? (a_key < b_key) : (a_id < b_id);
endmodule

FILE: hw/rtl/hq_ram.sv
`timescale 1ns / 1ps

// Entry store: one write port, two read ports with registered data.
module hq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 56,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end
endmodule

FILE: hw/rtl/binary_min_heap_queue.sv
`timescale 1ns / 1ps

// Channel  Dir  Payload                           Handshake
// req      in   kind, entry_id, entry_key         valid/ready, beat at valid & ready
// rsp      out  top_id, status, occupancy         valid/ready, beat at valid & ready
//
// One op at a time: req.ready only while idle. One comparator and one write port in total.
// Push: read and compare each parent, moving it down while the new entry wins. Pop: read
// root and last entry, then per level read both children and compare left, then right.
// Peek: read root. Full push, empty read or unused kind: straight to the response.
// Reset (rst, synchronous) empties the heap; the store itself is not cleared.
// A result waiting on rsp does not block the next req beat; it only delays the next result.

module binary_min_heap_queue
  import hq_pkg::*;
#(
  parameter int CAPACITY  = HQ_CAPACITY,
  parameter int KEY_WIDTH = HQ_KEY_WIDTH,
  parameter int ID_WIDTH  = HQ_ID_WIDTH
) (
  input logic      clk,
  input logic      rst,
  hq_req_if.sink   req,
  hq_rsp_if.source rsp
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = KEY_WIDTH + ID_WIDTH;
  localparam int IW = AW + 2;                 // child index, room for 2*pos+2
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,    // read parent, or drop the held entry at the root
    S_UP_CMP,   // held entry vs parent
    S_RD0,      // read root (and last entry for pop)
    S_PEEK,
    S_POP_LD,
    S_DN_RD,    // read both children, or drop the held entry
    S_DN_L,     // left child vs held entry
    S_DN_R,     // right child vs best so far, move winner up
    S_RESP
  } state_t;

  state_t               state;
  logic [CW-1:0]        count;
  logic [AW-1:0]        pos;
  logic [EW-1:0]        hold;       // entry being sifted
  logic [EW-1:0]        best;
  logic                 best_child;
  logic [AW-1:0]        best_idx;
  logic                 pop_op;
  logic [ID_WIDTH-1:0]  res_top;
  logic [STATUS_W-1:0]  res_status;

  logic                 out_valid;
  logic [ID_WIDTH-1:0]  out_top;
  logic [STATUS_W-1:0]  out_status;
  logic [CW-1:0]        out_occ;

  // store and compare unit hookup
  logic                 we, re;
  logic [AW-1:0]        waddr, raddr_a, raddr_b;
  logic [EW-1:0]        wdata, rdata_a, rdata_b;
  logic [EW-1:0]        cmp_a, cmp_b;
  logic                 a_wins;

  // tree navigation
  logic [AW-1:0]        pos_dec, parent, last_addr;
  logic [IW-1:0]        l_idx, r_idx, count_ext;
  logic                 l_ok, r_ok, take_r;

  assign pos_dec   = pos - AW'(1);
  assign parent    = pos_dec >> 1;
  assign last_addr = AW'(count - CW'(1));
  assign l_idx     = IW'({pos, 1'b1});
  assign r_idx     = l_idx + IW'(1);
  assign count_ext = IW'(count);
  assign l_ok      = l_idx < count_ext;
  assign r_ok      = r_idx < count_ext;
  assign take_r    = r_ok && a_wins;

  hq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (EW),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  hq_cmp #(
    .KEY_WIDTH (KEY_WIDTH),
    .ID_WIDTH  (ID_WIDTH)
  ) u_cmp (
    .a      (cmp_a),
    .b      (cmp_b),
    .a_wins (a_wins)
  );

  // Store access and comparator operand select per sequencer step.
  always_comb begin
    we      = 1'b0;
    waddr   = pos;
    wdata   = hold;
    re      = 1'b0;
    raddr_a = '0;
    raddr_b = last_addr;
    cmp_a   = hold;
    cmp_b   = rdata_a;
    case (state)
      S_UP_RD: begin
        if (pos == '0) begin
          we = 1'b1;
        end else begin
          re      = 1'b1;
          raddr_a = parent;
        end
      end
      S_UP_CMP: begin
        // parent moves down into the hole, or the held entry settles here
        we    = 1'b1;
        wdata = a_wins ? rdata_a : hold;
      end
      S_RD0: begin
        re = 1'b1;
      end
      S_DN_RD: begin
        if (!l_ok) begin
          we = 1'b1;
        end else begin
          re      = 1'b1;
          raddr_a = l_idx[AW-1:0];
          raddr_b = r_idx[AW-1:0];
        end
      end
      S_DN_L: begin
        cmp_a = rdata_a;
        cmp_b = hold;
      end
      S_DN_R: begin
        cmp_a = rdata_b;
        cmp_b = best;
        we    = 1'b1;
        if (take_r) begin
          wdata = rdata_b;
        end else if (best_child) begin
          wdata = best;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // S_RESP reloads the output register itself
      if (out_valid && rsp.ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            res_top <= '0;
            pop_op  <= (req.kind == KIND_POP);
            if (req.kind == KIND_PUSH) begin
              if (count == FULL_COUNT) begin
                res_status <= ST_FULL;
                state      <= S_RESP;
              end else begin
                res_status <= ST_OK;
                hold       <= {req.entry_key, req.entry_id};
                pos        <= AW'(count);
                count      <= count + CW'(1);
                state      <= S_UP_RD;
              end
            end else if (req.kind == KIND_POP || req.kind == KIND_PEEK) begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_RESP;
              end else begin
                res_status <= ST_OK;
                state      <= S_RD0;
              end
            end else begin
              // unused kind: answer ok, touch nothing
              res_status <= ST_OK;
              state      <= S_RESP;
            end
          end
        end
        S_UP_RD: begin
          state <= (pos == '0) ? S_RESP : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (a_wins) begin
            pos   <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_RESP;
          end
        end
        S_RD0: begin
          state <= pop_op ? S_POP_LD : S_PEEK;
        end
        S_PEEK: begin
          res_top <= rdata_a[ID_WIDTH-1:0];
          state   <= S_RESP;
        end
        S_POP_LD: begin
          res_top <= rdata_a[ID_WIDTH-1:0];
          hold    <= rdata_b;
          count   <= count - CW'(1);
          pos     <= '0;
          state   <= S_DN_RD;
        end
        S_DN_RD: begin
          state <= l_ok ? S_DN_L : S_RESP;
        end
        S_DN_L: begin
          best_idx <= l_idx[AW-1:0];
          if (a_wins) begin
            best       <= rdata_a;
            best_child <= 1'b1;
          end else begin
            best       <= hold;
            best_child <= 1'b0;
          end
          state <= S_DN_R;
        end
        S_DN_R: begin
          if (take_r) begin
            pos   <= r_idx[AW-1:0];
            state <= S_DN_RD;
          end else if (best_child) begin
            pos   <= best_idx;
            state <= S_DN_RD;
          end else begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_top    <= res_top;
            out_status <= res_status;
            out_occ    <= count;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.top_id    = out_top;
  assign rsp.status    = out_status;
  assign rsp.occupancy = out_occ;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count above capacity");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !we)
    else $error("store written while idle");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.kind == KIND_PUSH && count != FULL_COUNT)
      |=> (count == $past(count) + CW'(1)))
    else $error("accepted push did not grow the heap");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ST_FULL) |-> (out_occ == FULL_COUNT && out_top == '0))
    else $error("full status with heap not full");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ST_EMPTY) |-> (out_occ == '0 && out_top == '0))
    else $error("empty status with entries held");

endmodule

FILE: tb/binary_min_heap_queue_test.sv
`timescale 1ns / 1ps

module binary_min_heap_queue_test;
  import hq_pkg::*;

  localparam int CAP   = HQ_CAPACITY;
  localparam int KEY_W = HQ_KEY_WIDTH;
  localparam int ID_W  = HQ_ID_WIDTH;
  localparam int OCC_W = $clog2(CAP + 1);

  // The one kind code the block does not act on; it still answers with a beat.
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

  // Cycles with no beat on either channel before the run is declared hung.
  // Covers the long response hold below plus the slowest pop, with margin.
  localparam int HANG_LIMIT = 4000;
  localparam int RSP_HOLD_CYCLES = 400;
  // Drain time after the last result, longer than the slowest pop.
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic [KEY_W-1:0]  key;
  } op_t;

  typedef struct packed {
    logic [ID_W-1:0]     top_id;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } outcome_t;

  logic clk;
  logic rst;

  hq_req_if #(.KEY_WIDTH(KEY_W), .ID_WIDTH(ID_W)) req_ch ();
  hq_rsp_if #(.ID_WIDTH(ID_W), .OCC_WIDTH(OCC_W)) rsp_ch ();

  binary_min_heap_queue #(
    .CAPACITY (CAP),
    .KEY_WIDTH(KEY_W),
    .ID_WIDTH (ID_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Ops waiting to be offered, and outcomes the heap owes us, oldest first.
  op_t      op_backlog[$];
  outcome_t outcome_due[$];

  int errors        = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles   = 0;
  logic rsp_hold    = 1'b0;

  // Shadow heap: key/id pairs kept in array order, same layout as a binary heap.
  logic [KEY_W-1:0] heap_key[CAP];
  logic [ID_W-1:0]  heap_id[CAP];
  int               heap_count = 0;

  // Entry i beats entry j: smaller key, or equal key and smaller id.
  function automatic bit ranks_first(int i, int j);
    if (heap_key[i] != heap_key[j])
      return heap_key[i] < heap_key[j];
    return heap_id[i] < heap_id[j];
  endfunction

  function automatic void heap_swap(int i, int j);
    logic [KEY_W-1:0] k;
    logic [ID_W-1:0]  d;
    k = heap_key[i];
    d = heap_id[i];
    heap_key[i] = heap_key[j];
    heap_id[i]  = heap_id[j];
    heap_key[j] = k;
    heap_id[j]  = d;
  endfunction

  // Applies one op to the shadow heap and returns the beat the block must send.
  function automatic outcome_t heap_apply(op_t op);
    outcome_t res;
    int pos, up, lc, rc, best;
    res = '0;
    res.status = ST_OK;
    case (op.kind)
      KIND_PUSH: begin
        if (heap_count >= CAP) begin
          res.status = ST_FULL;
        end else begin
          heap_key[heap_count] = op.key;
          heap_id[heap_count]  = op.id;
          pos = heap_count;
          heap_count++;
          while (pos > 0) begin
            up = (pos - 1) / 2;
            if (!ranks_first(pos, up))
              break;
            heap_swap(pos, up);
            pos = up;
          end
        end
      end
      KIND_POP: begin
        if (heap_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.top_id = heap_id[0];
          heap_count--;
          heap_key[0] = heap_key[heap_count];
          heap_id[0]  = heap_id[heap_count];
          pos = 0;
          forever begin
            lc = 2 * pos + 1;
            rc = lc + 1;
            best = pos;
            if (lc < heap_count && ranks_first(lc, best))
              best = lc;
            if (rc < heap_count && ranks_first(rc, best))
              best = rc;
            if (best == pos)
              break;
            heap_swap(pos, best);
            pos = best;
          end
        end
      end
      KIND_PEEK: begin
        if (heap_count == 0)
          res.status = ST_EMPTY;
        else
          res.top_id = heap_id[0];
      end
      default: ;
    endcase
    res.occupancy = heap_count[OCC_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: offers the backlog, idling at random between beats. The op
  // is predicted at the edge where it is taken, so prediction order matches the
  // order in which the block serves ops.
  // ---------------------------------------------------------------------------
  op_t next_op;

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        outcome_due.push_back(heap_apply('{req_ch.kind, req_ch.entry_id, req_ch.entry_key}));
      if (!req_ch.valid || req_ch.ready) begin
        if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_op = op_backlog.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.kind      <= next_op.kind;
          req_ch.entry_id  <= next_op.id;
          req_ch.entry_key <= next_op.key;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response monitor: each beat is matched against the oldest owed outcome.
  // rsp_hold forces a long back-pressure stretch on top of the random stalls.
  // ---------------------------------------------------------------------------
  outcome_t want, seen;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen = '{rsp_ch.top_id, rsp_ch.status, rsp_ch.occupancy};
        if (outcome_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat: expected none, got id %0d st %0d occ %0d",
                   $time, seen.top_id, seen.status, seen.occupancy);
        end else begin
          want = outcome_due.pop_front();
          if (seen.top_id !== want.top_id) begin
            errors++;
            $display("%0t: top_id mismatch: expected %0d, got %0d",
                     $time, want.top_id, seen.top_id);
          end
          if (seen.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, seen.status);
          end
          if (seen.occupancy !== want.occupancy) begin
            errors++;
            $display("%0t: occupancy mismatch: expected %0d, got %0d",
                     $time, want.occupancy, seen.occupancy);
          end
        end
      end
      rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hang detector: any beat on either channel counts as progress.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus. Apart from the reset release, control changes happen on the
  // falling edge so the clocked processes above never race with them.
  // ---------------------------------------------------------------------------
  function automatic logic [KEY_W-1:0] pick_key();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return KEY_W'($urandom_range(7));    // dense keys force id tie-breaks
      1: return $urandom_range(1) ? '1 : '0;  // key extremes
      default: return wide[KEY_W-1:0];
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    return $urandom_range(1) ? ID_W'($urandom) : ID_W'($urandom_range(3));
  endfunction

  function automatic void queue_op(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                   logic [KEY_W-1:0] key);
    op_backlog.push_back('{kind, id, key});
  endfunction

  // Push past capacity so the full case shows up, then pop down to two entries, peeking every eighth op.
  function automatic void queue_fill_drain();
    for (int n = 0; n < CAP + 6; n++)
      queue_op(KIND_PUSH, pick_id(), pick_key());
    for (int n = 0; n < CAP + 6; n++)
      queue_op((n % 8 == 7) ? KIND_PEEK : KIND_POP, pick_id(), pick_key());
  endfunction

  // Mixed traffic, leaning on push so occupancy wanders across the whole range.
  function automatic void queue_mix(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 45)
        queue_op(KIND_PUSH, pick_id(), pick_key());
      else if (r < 80)
        queue_op(KIND_POP, pick_id(), pick_key());
      else if (r < 95)
        queue_op(KIND_PEEK, pick_id(), pick_key());
      else
        queue_op(KIND_NOP, pick_id(), pick_key());
    end
  endfunction

  // Done once nothing is queued, nothing is on offer and nothing is owed.
  task automatic wait_drained();
    do
      @(negedge clk);
    while (op_backlog.size() != 0 || req_ch.valid || outcome_due.size() != 0);
  endtask

  initial begin
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty-heap reads, unused kind, key/id extremes, equal keys
    // resolved by id, pop down to empty and past it.
    queue_op(KIND_PEEK, '0, '0);
    queue_op(KIND_POP,  '0, '0);
    queue_op(KIND_NOP,  '1, '1);
    queue_op(KIND_PUSH, '1, '1);
    queue_op(KIND_PUSH, '0, '0);
    queue_op(KIND_PEEK, '0, '0);
    queue_op(KIND_PUSH, 8'd9,   48'd5);
    queue_op(KIND_PUSH, 8'd3,   48'd5);
    queue_op(KIND_PUSH, 8'd200, 48'd5);
    queue_op(KIND_NOP,  '0, '0);
    queue_op(KIND_PEEK, '0, '0);
    for (int n = 0; n < 6; n++)
      queue_op(KIND_POP, '0, '0);
    queue_op(KIND_PUSH, 8'h80, {1'b1, {(KEY_W-1){1'b0}}});
    queue_op(KIND_PUSH, 8'h01, 48'd1);
    queue_op(KIND_POP,  '0, '0);
    queue_op(KIND_POP,  '0, '0);
    queue_op(KIND_PEEK, '0, '0);
    wait_drained();

    // Three phases: receiver-heavy idling, sender-heavy, then full throughput.
    // Each phase starts from an idle block, so the sender pauses until every
    // owed result is back.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 27; recv_idle_pct = 55; end
        1: begin send_idle_pct = 55; recv_idle_pct = 27; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      queue_fill_drain();
      queue_mix(150);
      if (ph == 0) begin
        // Long back-pressure while requests keep coming: the block must stall
        // its request side once a result is stuck.
        rsp_hold = 1'b1;
        repeat (RSP_HOLD_CYCLES) @(negedge clk);
        rsp_hold = 1'b0;
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/hq_pkg.sv
hw/rtl/hq_req_if.sv
hw/rtl/hq_rsp_if.sv
hw/rtl/hq_cmp.sv
hw/rtl/hq_ram.sv
hw/rtl/binary_min_heap_queue.sv
tb/binary_min_heap_queue_test.sv
